/* src/bos_pkg.sv */
package bos_pkg;

  localparam int unsigned NumKeys  = 4;
  localparam int unsigned KeyW     = 2;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned FieldW   = 12;
  localparam logic [7:0]  SpaceByte = 8'd32;
  localparam logic [IdxW-1:0] IdxMax = 4'd15;

  localparam logic [KeyW-1:0] KEY_ROOT   = 2'd0;
  localparam logic [KeyW-1:0] KEY_FSTYPE = 2'd1;
  localparam logic [KeyW-1:0] KEY_FLAGS  = 2'd2;
  localparam logic [KeyW-1:0] KEY_ALT    = 2'd3;

  localparam logic [0:NumKeys-1][IdxW-1:0] KeyLen = '{4'd5, 4'd11, 4'd10, 4'd8};

  localparam logic [0:NumKeys-1][0:15][7:0] KeyText = '{
    '{"r", "o", "o", "t", "=", 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "o", "o", "t", "f", "s", "t", "y",
      "p", "e", "=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "o", "o", "t", "f", "l", "a", "g",
      "s", "=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"a", "l", "t", "r", "o", "o", "t", "=",
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  typedef struct packed {
    logic               hit;
    logic [KeyW-1:0]    key;
    logic [NumKeys-1:0] keys;
  } match_t;

  typedef struct packed {
    logic              found;
    logic [FieldW-1:0] start;
    logic [FieldW-1:0] len;
  } opt_t;

  typedef opt_t [NumKeys-1:0] result_t;

endpackage

/* src/bos_in_if.sv */
interface bos_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_char;

  modport source (output valid, output char_byte, output last_char, input ready);
  modport sink   (input valid, input char_byte, input last_char, output ready);
endinterface

/* src/bos_out_if.sv */
interface bos_out_if;
  logic        valid;
  logic        ready;
  logic        root_found;
  logic [11:0] root_start;
  logic [11:0] root_len;
  logic        fstype_found;
  logic [11:0] fstype_start;
  logic [11:0] fstype_len;
  logic        flags_found;
  logic [11:0] flags_start;
  logic [11:0] flags_len;
  logic        alt_found;
  logic [11:0] alt_start;
  logic [11:0] alt_len;

  modport source (
    output valid, input ready,
    output root_found, output root_start, output root_len,
    output fstype_found, output fstype_start, output fstype_len,
    output flags_found, output flags_start, output flags_len,
    output alt_found, output alt_start, output alt_len
  );
  modport sink (
    input valid, output ready,
    input root_found, input root_start, input root_len,
    input fstype_found, input fstype_start, input fstype_len,
    input flags_found, input flags_start, input flags_len,
    input alt_found, input alt_start, input alt_len
  );
endinterface

/* src/bos_match.sv */
module bos_match (
  input  logic [7:0]                   byte_i,
  input  logic [bos_pkg::IdxW-1:0]     idx_i,
  input  logic [bos_pkg::NumKeys-1:0]  keys_i,
  output bos_pkg::match_t              match_o
);

  logic [bos_pkg::NumKeys-1:0] ok;
  logic [bos_pkg::NumKeys-1:0] done;

  always_comb begin
    for (int k = 0; k < bos_pkg::NumKeys; k++) begin
      ok[k] = keys_i[k] && (idx_i < bos_pkg::KeyLen[k])
              && (byte_i == bos_pkg::KeyText[k][idx_i]);
      done[k] = ok[k] && ((idx_i + 4'd1) == bos_pkg::KeyLen[k]);
    end
  end

  always_comb begin
    match_o.hit  = |done;
    match_o.keys = ok;
    priority if (done[0]) begin
      match_o.key = bos_pkg::KEY_ROOT;
    end else if (done[1]) begin
      match_o.key = bos_pkg::KEY_FSTYPE;
    end else if (done[2]) begin
      match_o.key = bos_pkg::KEY_FLAGS;
    end else begin
      match_o.key = bos_pkg::KEY_ALT;
    end
  end

endmodule

/* src/bos_scan.sv */
module bos_scan #(
  parameter int unsigned MAX_LINE = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  output bos_pkg::result_t res_o
);

  localparam int unsigned PW = $clog2(MAX_LINE);
  localparam logic [PW-1:0] PosMax = PW'(MAX_LINE - 1);
  localparam int unsigned NK = bos_pkg::NumKeys;

  logic [PW-1:0]               pos_q, pos_d;
  logic [bos_pkg::IdxW-1:0]    idx_q, idx_d;
  logic [NK-1:0]               keys_q, keys_d;
  logic                        cap_q, cap_d;
  logic [bos_pkg::KeyW-1:0]    cap_key_q, cap_key_d;
  logic [NK-1:0]               found_q, found_d;
  logic [NK-1:0][PW-1:0]       start_q, start_d;
  logic [NK-1:0][PW-1:0]       len_q, len_d;

  bos_pkg::match_t m;
  logic            space;
  logic [PW-1:0]   pos_inc;
  logic [PW-1:0]   len_inc;

  bos_match u_match (
    .byte_i  (byte_i),
    .idx_i   (idx_q),
    .keys_i  (keys_q),
    .match_o (m)
  );

  assign space   = (byte_i == bos_pkg::SpaceByte);
  assign pos_inc = (pos_q < PosMax) ? pos_q + 1'b1 : PosMax;
  assign len_inc = (len_q[cap_key_q] < PosMax) ? len_q[cap_key_q] + 1'b1 : PosMax;

  always_comb begin
    pos_d     = pos_inc;
    idx_d     = idx_q;
    keys_d    = keys_q;
    cap_d     = cap_q;
    cap_key_d = cap_key_q;
    found_d   = found_q;
    start_d   = start_q;
    len_d     = len_q;
    if (space) begin
      idx_d  = '0;
      keys_d = '1;
      cap_d  = 1'b0;
    end else begin
      if (idx_q < bos_pkg::IdxMax) begin
        idx_d = idx_q + 1'b1;
      end
      if (cap_q) begin
        len_d[cap_key_q] = len_inc;
      end else if (m.hit) begin
        found_d[m.key] = 1'b1;
        start_d[m.key] = pos_inc;
        len_d[m.key]   = '0;
        cap_d          = 1'b1;
        cap_key_d      = m.key;
        keys_d         = '0;
      end else begin
        keys_d = m.keys;
      end
    end
  end

  for (genvar k = 0; k < NK; k++) begin : g_res
    logic [PW+bos_pkg::FieldW-1:0] start_ext;
    logic [PW+bos_pkg::FieldW-1:0] len_ext;
    assign start_ext      = {{bos_pkg::FieldW{1'b0}}, start_d[k]};
    assign len_ext        = {{bos_pkg::FieldW{1'b0}}, len_d[k]};
    assign res_o[k].found = found_d[k];
    assign res_o[k].start = start_ext[bos_pkg::FieldW-1:0];
    assign res_o[k].len   = len_ext[bos_pkg::FieldW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      idx_q     <= '0;
      keys_q    <= '1;
      cap_q     <= 1'b0;
      cap_key_q <= bos_pkg::KEY_ROOT;
      found_q   <= '0;
      start_q   <= '0;
      len_q     <= '0;
    end else if (step_i) begin
      if (last_i) begin
        pos_q     <= '0;
        idx_q     <= '0;
        keys_q    <= '1;
        cap_q     <= 1'b0;
        cap_key_q <= bos_pkg::KEY_ROOT;
        found_q   <= '0;
        start_q   <= '0;
        len_q     <= '0;
      end else begin
        pos_q     <= pos_d;
        idx_q     <= idx_d;
        keys_q    <= keys_d;
        cap_q     <= cap_d;
        cap_key_q <= cap_key_d;
        found_q   <= found_d;
        start_q   <= start_d;
        len_q     <= len_d;
      end
    end
  end

endmodule

/* src/boot_option_scanner.sv */
// Channel  Modport  Transfer carries
// in_i     sink     char_byte, last_char
// out_o    source   found/start/len for root, fstype, flags, alt
//
// One byte per cycle unless a last byte waits on a full result register: each byte is
// held in the input register, then the scan logic updates the position and match registers.
// The byte flagged last is held in the input register, then loads the result register.
// The input stalls only while the last byte of a line waits on a full result register.
// Reset clears all scan state; the scanner also returns to reset state after each last byte.
module boot_option_scanner #(
  parameter int unsigned MAX_LINE = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bos_in_if.sink    in_i,
  bos_out_if.source out_o
);

  logic       in_vld_q, in_vld_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       out_vld_q, out_vld_d;
  logic       adv;
  logic       in_xfer;
  logic       load;

  bos_pkg::result_t res;
  bos_pkg::result_t res_q;

  bos_scan #(
    .MAX_LINE (MAX_LINE)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .byte_i (byte_q),
    .last_i (last_q),
    .res_o  (res)
  );

  assign adv        = in_vld_q && (!last_q || !out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;
  assign in_xfer    = in_i.valid && in_i.ready;
  assign load       = adv && last_q;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_xfer) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      byte_q <= in_i.char_byte;
      last_q <= in_i.last_char;
    end
    if (load) begin
      res_q <= res;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.root_found   = res_q[bos_pkg::KEY_ROOT].found;
  assign out_o.root_start   = res_q[bos_pkg::KEY_ROOT].start;
  assign out_o.root_len     = res_q[bos_pkg::KEY_ROOT].len;
  assign out_o.fstype_found = res_q[bos_pkg::KEY_FSTYPE].found;
  assign out_o.fstype_start = res_q[bos_pkg::KEY_FSTYPE].start;
  assign out_o.fstype_len   = res_q[bos_pkg::KEY_FSTYPE].len;
  assign out_o.flags_found  = res_q[bos_pkg::KEY_FLAGS].found;
  assign out_o.flags_start  = res_q[bos_pkg::KEY_FLAGS].start;
  assign out_o.flags_len    = res_q[bos_pkg::KEY_FLAGS].len;
  assign out_o.alt_found    = res_q[bos_pkg::KEY_ALT].found;
  assign out_o.alt_start    = res_q[bos_pkg::KEY_ALT].start;
  assign out_o.alt_len      = res_q[bos_pkg::KEY_ALT].len;

endmodule

/* tb/sv/boot_option_scanner_test.sv */
module boot_option_scanner_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] byte_t;
  typedef byte_t line_t[$];

  localparam int unsigned     CycleLimit   = 400000;
  localparam int unsigned     RxHoldCycles = 300;
  localparam int unsigned     RandomItems  = 300;
  localparam int unsigned     TailCycles   = 8;
  localparam logic [bos_pkg::FieldW-1:0] PosMax = 12'hFFF;

  logic clk_i = 1'b0;
  logic rst_ni;

  bos_in_if  in_ch ();
  bos_out_if out_ch ();

  boot_option_scanner #(
    .MAX_LINE(4096)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  string key_word[bos_pkg::NumKeys] = '{"root=", "rootfstype=", "rootflags=", "altroot="};
  string opt_label[bos_pkg::NumKeys] = '{"root", "fstype", "flags", "alt"};

  // scanner shadow state
  logic [bos_pkg::FieldW-1:0]  line_pos;
  int unsigned                 word_idx;
  logic [bos_pkg::NumKeys-1:0] keys_live;
  bit                          capturing;
  int unsigned                 cap_key;
  bos_pkg::result_t            opts;

  bos_pkg::result_t option_q[$];
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          rx_hold_req = 1'b0;
  bit          rx_hold_seen = 1'b0;
  int unsigned rx_stall_left = 0;

  function automatic logic [bos_pkg::FieldW-1:0] bump(input logic [bos_pkg::FieldW-1:0] v);
    return (v < PosMax) ? v + 1'b1 : PosMax;
  endfunction

  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic byte_t value_byte();
    byte_t b;
    if ($urandom_range(0, 3) == 0) begin
      b = byte_t'($urandom_range(0, 255));
      if (b == bos_pkg::SpaceByte) b = 8'd33;
    end else begin
      b = byte_t'($urandom_range(33, 126));
    end
    return b;
  endfunction

  function automatic line_t text_bytes(input string s);
    line_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(byte_t'(s[i]));
    return q;
  endfunction

  task automatic clear_scan();
    line_pos  = '0;
    word_idx  = 0;
    keys_live = '1;
    capturing = 1'b0;
    cap_key   = bos_pkg::NumKeys;
    opts      = '0;
  endtask

  task automatic scan_byte(input byte_t b, input logic last);
    if (b == bos_pkg::SpaceByte) begin
      word_idx  = 0;
      keys_live = '1;
      capturing = 1'b0;
      cap_key   = bos_pkg::NumKeys;
    end else begin
      if (capturing) begin
        opts[cap_key].len = bump(opts[cap_key].len);
      end else begin
        for (int k = 0; k < bos_pkg::NumKeys; k++) begin
          if (keys_live[k]) begin
            if (word_idx >= key_word[k].len() || b != byte_t'(key_word[k][word_idx])) begin
              keys_live[k] = 1'b0;
            end else if (word_idx + 1 == key_word[k].len()) begin
              opts[k].found = 1'b1;
              opts[k].start = bump(line_pos);
              opts[k].len   = '0;
              cap_key       = k;
              capturing     = 1'b1;
              keys_live     = '0;
            end
          end
        end
      end
      if (word_idx < 15) word_idx++;
    end
    line_pos = bump(line_pos);
    if (last) begin
      option_q.push_back(opts);
      clear_scan();
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_byte(input byte_t b, input logic last);
    int unsigned gap;
    gap = 0;
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) gap = idle_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_byte <= b;
    in_ch.last_char <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    scan_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_line(input line_t line);
    for (int i = 0; i < line.size(); i++) send_byte(line[i], i == line.size() - 1);
  endtask

  task automatic wait_drain();
    do @(posedge clk_i); while (option_q.size() != 0);
  endtask

  task automatic append_word(ref line_t line);
    int unsigned pick, k, n, i;
    string key;
    pick = $urandom_range(0, 99);
    k    = $urandom_range(0, bos_pkg::NumKeys - 1);
    key  = key_word[k];
    if (pick < 60) begin
      for (i = 0; i < key.len(); i++) line.push_back(byte_t'(key[i]));
      n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 10);
      repeat (n) line.push_back(value_byte());
      // key text inside a value stays part of the value
      if ($urandom_range(0, 9) == 0) begin
        key = key_word[$urandom_range(0, bos_pkg::NumKeys - 1)];
        for (i = 0; i < key.len(); i++) line.push_back(byte_t'(key[i]));
      end
    end else if (pick < 80) begin
      n = $urandom_range(1, key.len() - 1);
      for (i = 0; i < n; i++) line.push_back(byte_t'(key[i]));
      n = $urandom_range(0, 3);
      repeat (n) line.push_back(value_byte());
    end else if (pick < 90) begin
      // empty word
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) line.push_back(byte_t'($urandom_range(0, 255)));
    end
  endtask

  task automatic make_line(ref line_t line);
    int unsigned words;
    line.delete();
    if ($urandom_range(0, 7) == 0) line.push_back(bos_pkg::SpaceByte);
    words = $urandom_range(1, 6);
    for (int w = 0; w < words; w++) begin
      append_word(line);
      if (w != words - 1) begin
        line.push_back(bos_pkg::SpaceByte);
        if ($urandom_range(0, 7) == 0) line.push_back(bos_pkg::SpaceByte);
      end
    end
    if ($urandom_range(0, 9) == 0) line.push_back(bos_pkg::SpaceByte);
    if (line.size() == 0) line.push_back(value_byte());
  endtask

  task automatic test_directed();
    line_t line;
    send_line(text_bytes("altroot= root=a"));
    line = text_bytes("rootflags=");
    line.push_back(8'h00);
    line.push_back(8'hFF);
    send_line(line);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(bos_pkg::SpaceByte, 1'b1);
  endtask

  task automatic test_long_line();
    line_t line;
    line = text_bytes("root=");
    repeat (60) line.push_back(value_byte());
    line.push_back(bos_pkg::SpaceByte);
    line = {line, text_bytes("altroot=zz")};
    send_line(line);
  endtask

  task automatic test_rx_hold();
    line_t line;
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    rx_hold_req <= ~rx_hold_req;
    repeat (40) begin
      line.delete();
      repeat ($urandom_range(1, 3)) line.push_back(byte_t'($urandom_range(0, 255)));
      send_line(line);
    end
  endtask

  task automatic test_drain_pause();
    line_t line;
    tx_idle_pct = 10;
    rx_idle_pct <= 10;
    repeat (3) begin
      make_line(line);
      send_line(line);
      in_ch.valid <= 1'b0;
      wait_drain();
    end
  endtask

  task automatic test_random_lines();
    line_t line;
    int unsigned target, lines_done;
    target     = bytes_sent + RandomItems;
    lines_done = 0;
    while (bytes_sent < target) begin
      if (lines_done % 8 == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            tx_idle_pct = 0;
            rx_idle_pct <= 0;
          end
          1: begin
            tx_idle_pct = 30;
            rx_idle_pct <= 0;
          end
          2: begin
            tx_idle_pct = 0;
            rx_idle_pct <= 30;
          end
          default: begin
            tx_idle_pct = 15;
            rx_idle_pct <= 15;
          end
        endcase
      end
      make_line(line);
      send_line(line);
      lines_done++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      rx_stall_left = 0;
    end else if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen  = rx_hold_req;
      rx_stall_left = RxHoldCycles;
      out_ch.ready <= 1'b0;
    end else if (rx_stall_left != 0) begin
      rx_stall_left--;
      out_ch.ready <= 1'b0;
    end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
      rx_stall_left = idle_len() - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_options
    bos_pkg::result_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got[bos_pkg::KEY_ROOT]   = {out_ch.root_found, out_ch.root_start, out_ch.root_len};
      got[bos_pkg::KEY_FSTYPE] = {out_ch.fstype_found, out_ch.fstype_start,
                                  out_ch.fstype_len};
      got[bos_pkg::KEY_FLAGS]  = {out_ch.flags_found, out_ch.flags_start, out_ch.flags_len};
      got[bos_pkg::KEY_ALT]    = {out_ch.alt_found, out_ch.alt_start, out_ch.alt_len};
      if (option_q.size() == 0) begin
        report_mismatch("result transfer with no line pending");
      end else begin
        want = option_q.pop_front();
        for (int k = 0; k < bos_pkg::NumKeys; k++) begin
          if (got[k].found !== want[k].found)
            report_mismatch($sformatf("%s_found got %0b expected %0b",
                                      opt_label[k], got[k].found, want[k].found));
          if (got[k].start !== want[k].start)
            report_mismatch($sformatf("%s_start got %0d expected %0d",
                                      opt_label[k], got[k].start, want[k].start));
          if (got[k].len !== want[k].len)
            report_mismatch($sformatf("%s_len got %0d expected %0d",
                                      opt_label[k], got[k].len, want[k].len));
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("boot_option_scanner verification failed");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.char_byte = '0;
    in_ch.last_char = 1'b0;
    clear_scan();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_long_line();
    test_rx_hold();
    test_drain_pause();
    test_random_lines();

    in_ch.valid <= 1'b0;
    wait_drain();
    repeat (TailCycles) @(posedge clk_i);
    if (option_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", option_q.size()));
    if (mismatch_count == 0) begin
      $display("boot_option_scanner verification clean");
    end else begin
      $display("boot_option_scanner verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/bos_pkg.sv
src/bos_in_if.sv
src/bos_out_if.sv
src/bos_match.sv
src/bos_scan.sv
src/boot_option_scanner.sv
tb/sv/boot_option_scanner_test.sv
